[rtl/core/ctia_pkg.sv]
// Package for the centroid track id assigner: table sizes, field widths,
// the track entry type and the sequencer state type. No dependencies.
package ctia_pkg;

   localparam int MAX_TRACKS = 64;
   localparam int ID_BITS    = 16;

   localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int CNT_W = $clog2(MAX_TRACKS + 1);

   localparam int COORD_W  = 12;
   localparam int CENTER_W = 13;
   localparam int SQ_W     = 2 * CENTER_W;
   localparam int SUM_W    = SQ_W + 1;
   localparam int LABEL_W  = 8;
   localparam int OBJ_ID_W = 16;
   localparam int RADIUS_W = 24;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(625);

   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 2;

   // req_tuser codes
   localparam logic OP_BOX = 1'b0;
   localparam logic OP_EOF = 1'b1;

   typedef struct packed {
      logic [ID_BITS-1:0]  ident;
      logic [CENTER_W-1:0] cy;
      logic [CENTER_W-1:0] cx;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_DX,
      ST_SRCH_DY,
      ST_NEW,
      ST_RESP,
      ST_EOF_SCAN,
      ST_EOF_MOVE
   } state_type;

endpackage

[rtl/core/ctia_dist.sv]
// Shared distance unit: squared absolute difference of two centre coordinates.
// Depends on ctia_pkg.
module ctia_dist (
   input  logic [ctia_pkg::CENTER_W-1:0] a,
   input  logic [ctia_pkg::CENTER_W-1:0] b,
   output logic [ctia_pkg::SQ_W-1:0]     sq
);
   import ctia_pkg::*;

   logic [CENTER_W-1:0] diff;

   assign diff = (a >= b) ? (a - b) : (b - a);
   assign sq   = SQ_W'(diff) * SQ_W'(diff);

endmodule

[rtl/core/centroid_track_id_assigner.sv]
// Top level of the centroid track id assigner: sequencer, track table memory
// and result register. Depends on ctia_pkg and ctia_dist.
//
// Each detection transaction (req_tuser = 0) is compared against the stored
// tracks, oldest first, by one shared squared-distance unit that handles dx
// and dy in turn: per track a table read, then dx^2, then dy^2 + compare.
// req_tready is high only while the block is idle. The result sits in an
// output register, so the next transaction is taken while it waits; a result
// only stalls the sequencer when the previous one has not been taken yet. An
// end-of-frame transaction (req_tuser = 1) gives no result and compacts the
// table with one table read/write per kept track. The track table is a
// single-port-write, single-port-read memory; used marks sit in flip-flops.
// match_radius_sq is written through csr_wr_en/csr_wr_data; the user must
// write it only while idle, the block itself does not enforce this.
module centroid_track_id_assigner (
   input  logic                              clock,
   input  logic                              reset,
   // request: tdata = box_x, box_y, box_w, box_h, class_label from bit 0 up
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ctia_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tuser,   // op: 0 box, 1 end of frame
   // response: tdata = out_x, out_y, out_w, out_h, track_id, out_label from bit 0 up
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ctia_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [ctia_pkg::RSP_TUSER_W-1:0]  rsp_tuser,   // is_new, table_full from bit 0 up
   // configuration: match_radius_sq
   input  logic                              csr_wr_en,
   input  logic [ctia_pkg::RADIUS_W-1:0]     csr_wr_data
);
   import ctia_pkg::*;

   state_type state_ff, state_in;

   // captured transaction
   logic [COORD_W-1:0]  box_x_ff, box_y_ff, box_w_ff, box_h_ff;
   logic [LABEL_W-1:0]  label_ff;
   logic [CENTER_W-1:0] cx_ff, cy_ff;

   // table state
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      kept_ff;
   logic [ID_BITS-1:0]    next_id_ff;
   logic [MAX_TRACKS-1:0] used_ff;
   logic [RADIUS_W-1:0]   radius_ff;

   // track memory
   entry_type             trk_mem [MAX_TRACKS];
   entry_type             rd_ff;
   logic                  mem_re, mem_we;
   logic [IDX_W-1:0]      mem_raddr, mem_waddr;
   entry_type             mem_wdata;

   // distance unit
   logic [CENTER_W-1:0]   dist_a, dist_b;
   logic [SQ_W-1:0]       dist_sq;
   logic [SQ_W-1:0]       sq_ff;
   logic [SUM_W-1:0]      sum;
   logic                  hit;

   // staged result and output register
   logic [OBJ_ID_W-1:0]   res_id_ff;
   logic                  res_new_ff, res_full_ff;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff;

   logic                  req_acc;
   logic                  rsp_free;
   logic                  idx_last;
   logic                  idx_end;
   logic                  idx_used;
   logic                  tbl_full;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid_ff || rsp_tready;
   assign idx_last = (idx_ff + CNT_W'(1)) == count_ff;
   assign idx_end  = (idx_ff == count_ff);
   assign idx_used = used_ff[idx_ff[IDX_W-1:0]];
   assign tbl_full = (count_ff == CNT_W'(MAX_TRACKS));

   ctia_dist u_dist (
      .a  (dist_a),
      .b  (dist_b),
      .sq (dist_sq)
   );

   // dy^2 joins the registered dx^2; strict compare against the radius
   assign sum = SUM_W'(sq_ff) + SUM_W'(dist_sq);
   assign hit = sum < SUM_W'(radius_ff);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_EOF)      state_in = ST_EOF_SCAN;
               else if (count_ff == '0)      state_in = ST_NEW;
               else                          state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD:  state_in = ST_SRCH_DX;
         ST_SRCH_DX:  state_in = ST_SRCH_DY;
         ST_SRCH_DY: begin
            if (hit)           state_in = ST_RESP;
            else if (idx_last) state_in = ST_NEW;
            else               state_in = ST_SRCH_RD;
         end
         ST_NEW:      state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         ST_EOF_SCAN: begin
            if (idx_end)       state_in = ST_IDLE;
            else if (idx_used) state_in = ST_EOF_MOVE;
         end
         ST_EOF_MOVE: state_in = ST_EOF_SCAN;
         default:     state_in = ST_IDLE;
      endcase
   end

   // ---------------- outputs of the sequencer ----------------
   always_comb begin
      req_tready = 1'b0;
      mem_re     = 1'b0;
      mem_raddr  = idx_ff[IDX_W-1:0];
      mem_we     = 1'b0;
      mem_waddr  = idx_ff[IDX_W-1:0];
      mem_wdata  = '{ident: rd_ff.ident, cy: cy_ff, cx: cx_ff};
      dist_a     = cx_ff;
      dist_b     = rd_ff.cx;
      case (state_ff)
         ST_IDLE:    req_tready = 1'b1;
         ST_SRCH_RD: mem_re = 1'b1;
         ST_SRCH_DY: begin
            dist_a = cy_ff;
            dist_b = rd_ff.cy;
            mem_we = hit;            // matched track takes the new centre
         end
         ST_NEW: begin
            mem_we    = !tbl_full;   // append at the end of the table
            mem_waddr = count_ff[IDX_W-1:0];
            mem_wdata = '{ident: next_id_ff, cy: cy_ff, cx: cx_ff};
         end
         ST_EOF_SCAN: mem_re = !idx_end && idx_used;
         ST_EOF_MOVE: begin
            mem_we    = 1'b1;        // kept track slides down
            mem_waddr = kept_ff[IDX_W-1:0];
            mem_wdata = rd_ff;
         end
         default: ;
      endcase
   end

   // ---------------- track memory ----------------
   always_ff @(posedge clock) begin
      if (mem_we) trk_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_ff <= trk_mem[mem_raddr];
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (state_ff == ST_RESP && rsp_free) rsp_tvalid_in = 1'b1;
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         next_id_ff    <= '0;
         used_ff       <= '0;
         radius_ff     <= RADIUS_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) radius_ff <= csr_wr_data;
         case (state_ff)
            ST_SRCH_DY: begin
               if (hit) used_ff[idx_ff[IDX_W-1:0]] <= 1'b1;
            end
            ST_NEW: begin
               next_id_ff <= next_id_ff + ID_BITS'(1);
               if (!tbl_full) begin
                  used_ff[count_ff[IDX_W-1:0]] <= 1'b1;
                  count_ff <= count_ff + CNT_W'(1);
               end
            end
            ST_EOF_SCAN: begin
               if (idx_end) begin
                  count_ff <= kept_ff;
                  used_ff  <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               box_x_ff <= req_tdata[11:0];
               box_y_ff <= req_tdata[23:12];
               box_w_ff <= req_tdata[35:24];
               box_h_ff <= req_tdata[47:36];
               label_ff <= req_tdata[55:48];
               cx_ff    <= CENTER_W'(req_tdata[11:0])  + CENTER_W'(req_tdata[35:25]);
               cy_ff    <= CENTER_W'(req_tdata[23:12]) + CENTER_W'(req_tdata[47:37]);
               idx_ff   <= '0;
               kept_ff  <= '0;
            end
         end
         ST_SRCH_DX: sq_ff <= dist_sq;
         ST_SRCH_DY: begin
            if (hit) begin
               res_id_ff   <= OBJ_ID_W'(rd_ff.ident);
               res_new_ff  <= 1'b0;
               res_full_ff <= 1'b0;
            end else begin
               idx_ff <= idx_ff + CNT_W'(1);
            end
         end
         ST_NEW: begin
            res_id_ff   <= OBJ_ID_W'(next_id_ff);
            res_new_ff  <= 1'b1;
            res_full_ff <= tbl_full;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_tdata_ff <= {label_ff, res_id_ff, box_h_ff, box_w_ff, box_y_ff, box_x_ff};
               rsp_tuser_ff <= {res_full_ff, res_new_ff};
            end
         end
         ST_EOF_SCAN: begin
            if (!idx_end && !idx_used) idx_ff <= idx_ff + CNT_W'(1);
         end
         ST_EOF_MOVE: begin
            idx_ff  <= idx_ff + CNT_W'(1);
            kept_ff <= kept_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[test/centroid_track_id_assigner_tb.sv]
// Self-checking testbench for centroid_track_id_assigner: a directed table, then
// frames of random detections checked against a track table kept in the bench.
// Depends on ctia_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module centroid_track_id_assigner_tb;
   import ctia_pkg::*;

   // Worst single transaction: a full search of the table, plus margin.
   localparam int SETTLE_CYCLES = 3 * MAX_TRACKS + 16;
   localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
   localparam int CENTER_MAX = 6142;   // (2*4095 + 4095) / 2

   typedef struct packed {
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  w;
      logic [COORD_W-1:0]  h;
      logic [OBJ_ID_W-1:0] ident;
      logic [LABEL_W-1:0]  label;
      logic                is_new;
      logic                full;
   } det_result_type;

   typedef struct {
      logic               op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
      logic [LABEL_W-1:0] label;
      bit                 typed_in;   // use the result below instead of the track table
      det_result_type     want;
   } stim_row_type;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_tvalid  = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata   = '0;
   logic                    req_tuser   = OP_BOX;
   logic                    rsp_tvalid;
   logic                    rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [RSP_TUSER_W-1:0]  rsp_tuser;
   logic                    csr_wr_en   = 1'b0;
   logic [RADIUS_W-1:0]     csr_wr_data = '0;

   // Track table as the bench sees it, updated at each accepted transaction.
   logic [CENTER_W-1:0] trk_cx    [MAX_TRACKS];
   logic [CENTER_W-1:0] trk_cy    [MAX_TRACKS];
   logic [ID_BITS-1:0]  trk_ident [MAX_TRACKS];
   bit                  trk_used  [MAX_TRACKS];
   int                  trk_count  = 0;
   logic [ID_BITS-1:0]  next_ident = '0;
   logic [RADIUS_W-1:0] radius_sq  = RADIUS_RESET;

   det_result_type pending_q [$];   // results still owed by the block, oldest first
   int          errors  = 0;
   bit          idle_on = 1'b0;  // random gaps on requests and stalls on results
   int          rsp_hold = 0;

   // Directed rows. Centres noted as (cx, cy); radius is the reset value 625.
   stim_row_type dir_rows [13] = '{
      // all zero: first id after reset
      '{OP_BOX, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 1'b1,
        '{12'd0, 12'd0, 12'd0, 12'd0, 16'd0, 8'd0, 1'b1, 1'b0}},
      // all ones, centre (6142, 6142): far from everything, next id
      '{OP_BOX, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd255, 1'b1,
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'd1, 8'd255, 1'b1, 1'b0}},
      // (10, 0): distance^2 100 to the first track, match
      '{OP_BOX, 12'd10, 12'd0, 12'd1, 12'd1, 8'd17, 1'b0, '0},
      // (0, 24): distance^2 676, no match
      '{OP_BOX, 12'd0, 12'd24, 12'd0, 12'd1, 8'd34, 1'b0, '0},
      // (25, 20): distance^2 exactly 625 to the first track, must not match
      '{OP_BOX, 12'd25, 12'd20, 12'd0, 12'd0, 8'd51, 1'b0, '0},
      // (49, 26): 612 to the newest track only
      '{OP_BOX, 12'd49, 12'd26, 12'd0, 12'd0, 8'd68, 1'b0, '0},
      // (5, 12): equally close to two tracks, the older one wins
      '{OP_BOX, 12'd5, 12'd12, 12'd0, 12'd0, 8'd85, 1'b0, '0},
      // end of frame with every box bit set: all tracks used, all kept
      '{OP_EOF, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 8'd255, 1'b0, '0},
      // (6142, 6142): revisits the second track only
      '{OP_BOX, 12'd4095, 12'd4095, 12'd4094, 12'd4094, 8'd9, 1'b0, '0},
      // end of frame: only the revisited track survives, compacted to slot 0
      '{OP_EOF, 12'd0, 12'd0, 12'd0, 12'd0, 8'd0, 1'b0, '0},
      // (0, 0): its old track is gone, fresh id
      '{OP_BOX, 12'd0, 12'd0, 12'd0, 12'd0, 8'd128, 1'b0, '0},
      // odd sizes round the centre down to (2047, 2047)
      '{OP_BOX, 12'd0, 12'd0, 12'd4095, 12'd4095, 8'd200, 1'b0, '0},
      '{OP_EOF, 12'd1365, 12'd2730, 12'd1365, 12'd2730, 8'd170, 1'b0, '0}
   };

   centroid_track_id_assigner dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Search oldest first; the first track strictly inside the radius takes the
   // detection. Otherwise a fresh id goes out and the centre is appended when
   // there is room.
   function automatic det_result_type assign_track(input logic [COORD_W-1:0] bx, by, bw, bh,
                                                   input logic [LABEL_W-1:0] lab);
      logic [CENTER_W:0]   sx, sy;
      logic [CENTER_W-1:0] cx, cy, dx, dy;
      logic [SUM_W-1:0]    dsq;
      det_result_type      r;
      bit                  hit;
      hit = 1'b0;
      sx = {bx, 1'b0} + bw;
      sy = {by, 1'b0} + bh;
      cx = sx[CENTER_W:1];
      cy = sy[CENTER_W:1];
      r.x = bx;
      r.y = by;
      r.w = bw;
      r.h = bh;
      r.label = lab;
      r.is_new = 1'b1;
      r.full = 1'b0;
      r.ident = '0;
      for (int i = 0; i < trk_count; i++) begin
         dx = (cx > trk_cx[i]) ? cx - trk_cx[i] : trk_cx[i] - cx;
         dy = (cy > trk_cy[i]) ? cy - trk_cy[i] : trk_cy[i] - cy;
         dsq = SUM_W'(dx) * SUM_W'(dx) + SUM_W'(dy) * SUM_W'(dy);
         if (dsq < SUM_W'(radius_sq)) begin
            trk_cx[i] = cx;
            trk_cy[i] = cy;
            trk_used[i] = 1'b1;
            r.ident = OBJ_ID_W'(trk_ident[i]);
            r.is_new = 1'b0;
            hit = 1'b1;
            break;
         end
      end
      if (!hit) begin
         r.ident = OBJ_ID_W'(next_ident);
         if (trk_count < MAX_TRACKS) begin
            trk_cx[trk_count] = cx;
            trk_cy[trk_count] = cy;
            trk_ident[trk_count] = next_ident;
            trk_used[trk_count] = 1'b1;
            trk_count++;
         end else begin
            r.full = 1'b1;
         end
         next_ident = next_ident + 1'b1;   // wraps with the id width
      end
      return r;
   endfunction

   // End of frame: keep used tracks in order, drop the rest, clear the marks.
   function automatic void close_frame();
      int kept;
      kept = 0;
      for (int i = 0; i < trk_count; i++) begin
         if (trk_used[i]) begin
            trk_cx[kept] = trk_cx[i];
            trk_cy[kept] = trk_cy[i];
            trk_ident[kept] = trk_ident[i];
            trk_used[kept] = 1'b0;
            kept++;
         end
      end
      for (int i = kept; i < MAX_TRACKS; i++)
         trk_used[i] = 1'b0;
      trk_count = kept;
   endfunction

   // Left edge and size of a box whose rounded-down centre is c.
   function automatic void box_edges(input int c, output logic [COORD_W-1:0] pos, size);
      int lo, hi, half;
      lo = (c > 4095) ? c - 4095 : 0;
      hi = (c < 2047) ? c : 2047;
      half = $urandom_range(hi, lo);
      size = COORD_W'(2 * half + $urandom_range(0, 1));
      pos = COORD_W'(c - half);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // One request transaction. tvalid stays high after acceptance so that
   // back-to-back transactions keep it raised between them; release_req lowers it.
   task automatic send_item(input logic op, input logic [COORD_W-1:0] bx, by, bw, bh,
                            input logic [LABEL_W-1:0] lab, input bit typed_in = 1'b0,
                            input det_result_type want = '0);
      int             gap;
      det_result_type predicted;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {lab, bh, bw, by, bx};
      do @(posedge clock); while (!req_tready);
      if (op == OP_EOF) begin
         close_frame();
      end else begin
         predicted = assign_track(bx, by, bw, bh, lab);
         pending_q.insert(pending_q.size(), typed_in ? want : predicted);
      end
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Block is idle once every result is in and an end-of-frame pass could
   // have finished behind the last one.
   task automatic drain();
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_radius(input logic [RADIUS_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      radius_sq = value;
   endtask

   // Frames of detections closed by an end of frame. Most boxes sit near a
   // stored track with jitter of up to jit pixels; some land anywhere, some are
   // fully random, and a few stray end-of-frame transactions break frames up.
   task automatic run_frames(input int n_items, input int max_dets, input int jit);
      int                 sent, ndet, kind, pick, cx, cy;
      logic [COORD_W-1:0] bx, by, bw, bh;
      sent = 0;
      while (sent < n_items) begin
         ndet = $urandom_range(0, max_dets);
         for (int d = 0; d < ndet; d++) begin
            kind = $urandom_range(0, 99);
            bx = COORD_W'($urandom);
            by = COORD_W'($urandom);
            bw = COORD_W'($urandom);
            bh = COORD_W'($urandom);
            if (kind < 5) begin
               send_item(OP_EOF, bx, by, bw, bh, LABEL_W'($urandom));
            end else begin
               if (kind >= 15) begin
                  if (trk_count > 0 && kind < 80) begin
                     pick = $urandom_range(0, trk_count - 1);
                     cx = int'(trk_cx[pick]) + int'($urandom_range(0, 2 * jit)) - jit;
                     cy = int'(trk_cy[pick]) + int'($urandom_range(0, 2 * jit)) - jit;
                  end else begin
                     cx = $urandom_range(0, CENTER_MAX);
                     cy = $urandom_range(0, CENTER_MAX);
                  end
                  cx = (cx < 0) ? 0 : (cx > CENTER_MAX) ? CENTER_MAX : cx;
                  cy = (cy < 0) ? 0 : (cy > CENTER_MAX) ? CENTER_MAX : cy;
                  box_edges(cx, bx, bw);
                  box_edges(cy, by, bh);
               end
               send_item(OP_BOX, bx, by, bw, bh, LABEL_W'($urandom));
            end
            sent++;
         end
         send_item(OP_EOF, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), LABEL_W'($urandom));
         sent++;
      end
      release_req();
      drain();
   endtask

   // Result side: random stall bursts while idling is on.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
         rsp_hold = $urandom_range(0, 12);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted result transaction is matched to the oldest expectation.
   always @(posedge clock) begin
      det_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            $display("%0t ns: result with none expected, tdata %h tuser %b",
                     $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_q.pop_front();
            check_field("out_x", 32'(want.x), 32'(rsp_tdata[11:0]));
            check_field("out_y", 32'(want.y), 32'(rsp_tdata[23:12]));
            check_field("out_w", 32'(want.w), 32'(rsp_tdata[35:24]));
            check_field("out_h", 32'(want.h), 32'(rsp_tdata[47:36]));
            check_field("track_id", 32'(want.ident), 32'(rsp_tdata[63:48]));
            check_field("out_label", 32'(want.label), 32'(rsp_tdata[71:64]));
            check_field("is_new", 32'(want.is_new), 32'(rsp_tuser[0]));
            check_field("table_full", 32'(want.full), 32'(rsp_tuser[1]));
         end
      end
   end

   initial begin
      logic [RADIUS_W-1:0] rnd_radius;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;

      // directed part at the reset radius
      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w,
                   dir_rows[i].h, dir_rows[i].label, dir_rows[i].typed_in, dir_rows[i].want);
      release_req();
      drain();

      // random phases over several radius settings
      set_radius(RADIUS_RESET);
      run_frames(400, 12, 40);
      set_radius('0);                // nothing matches: table fills, then table_full
      run_frames(150, 90, 40);
      set_radius(RADIUS_MAX);
      run_frames(200, 12, 3000);
      set_radius(RADIUS_W'(1));      // exact centre only
      run_frames(150, 12, 1);
      rnd_radius = RADIUS_W'($urandom);
      set_radius(rnd_radius);
      run_frames(300, 12, 1500);

      // closing stretch without gaps or stalls
      idle_on = 1'b0;
      set_radius(RADIUS_RESET);
      run_frames(200, 12, 40);

      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog: stops a run that has not finished in time and reports a mismatch.
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
